>>> rtl/core/htu_pkg.sv
// Shared types and constants of the homogeneous transform unit.
// Command codes, CORDIC constants and the arc-tangent table.
// No dependencies.
package htu_pkg;

  typedef enum logic [3:0] {
    CMD_IDENTITY  = 4'd0,
    CMD_ROTX      = 4'd1,
    CMD_ROTY      = 4'd2,
    CMD_ROTZ      = 4'd3,
    CMD_TRANSLATE = 4'd4,
    CMD_TRANSFORM = 4'd5,
    CMD_SAVE      = 4'd6,
    CMD_RESTORE   = 4'd7,
    CMD_CLEAR     = 4'd8
  } htu_cmd_t;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_W     = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [9:0] DEG_PER_TURN = 10'd360;

  // Control of the shared multiply-accumulate unit, one term half per transfer.
  typedef struct packed {
    logic en;
    logic first;
    logic hi;
    logic last;
  } mac_ctl_t;

  // atan(2^-i) in binary angle units, 2^32 per turn.
  function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return $signed({2'b00, r});
  endfunction

endpackage

>>> rtl/core/htu_if.sv
// Valid/ready channel interfaces for commands and transformed vertices.
// No dependencies.
interface htu_req_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic [3:0]                   cmd;
  logic signed [DATA_WIDTH-1:0] angle_deg;
  logic signed [DATA_WIDTH-1:0] in_x;
  logic signed [DATA_WIDTH-1:0] in_y;
  logic signed [DATA_WIDTH-1:0] in_z;
  logic signed [DATA_WIDTH-1:0] in_w;
  modport source (output valid, cmd, angle_deg, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, cmd, angle_deg, in_x, in_y, in_z, in_w, output ready);
endinterface

interface htu_rsp_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] out_x;
  logic signed [DATA_WIDTH-1:0] out_y;
  logic signed [DATA_WIDTH-1:0] out_z;
  logic signed [DATA_WIDTH-1:0] out_w;
  modport source (output valid, out_x, out_y, out_z, out_w, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

>>> rtl/core/htu_mac.sv
// Shared multiply-accumulate unit: half-width products, exact accumulation,
// round half up and saturation of one dot product. Depends on htu_pkg.
module htu_mac import htu_pkg::*; #(
  parameter int A_WIDTH   = 34,
  parameter int B_WIDTH   = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mac_ctl_t                  ctl,
  input  logic signed [A_WIDTH-1:0] a,
  input  logic signed [B_WIDTH-1:0] b,
  output logic signed [B_WIDTH-1:0] res,
  output logic                      done
);
  localparam int H  = (B_WIDTH + 1) / 2;
  localparam int PW = A_WIDTH + B_WIDTH;
  localparam int AW = PW + 3;
  localparam logic signed [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);
  localparam logic [B_WIDTH-1:0] W_MAX = {1'b0, {(B_WIDTH-1){1'b1}}};
  localparam logic [B_WIDTH-1:0] W_MIN = {1'b1, {(B_WIDTH-1){1'b0}}};

  logic signed [A_WIDTH+H:0]           p_lo;
  logic signed [A_WIDTH+B_WIDTH-H-1:0] p_hi;
  logic signed [PW-1:0]                prod;
  logic                                p_en, p_first, p_last;
  logic signed [AW-1:0]                acc, rnd, shd;
  logic                                fits;

  assign p_lo = a * $signed({1'b0, b[H-1:0]});
  assign p_hi = a * $signed(b[B_WIDTH-1:H]);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_en  <= 1'b0;
      p_first <= 1'b0;
      p_last <= 1'b0;
      done  <= 1'b0;
    end else begin
      p_en    <= ctl.en;
      p_first <= ctl.first;
      p_last  <= ctl.last;
      done    <= p_en && p_last;
    end
    if (ctl.en) begin
      prod <= ctl.hi ? (PW'(p_hi) <<< H) : PW'(p_lo);
    end
    if (p_en) begin
      acc <= (p_first ? '0 : acc) + AW'(prod);
    end
  end

  assign rnd  = acc + HALF;
  assign shd  = rnd >>> FRAC_BITS;
  assign fits = (&shd[AW-1:B_WIDTH-1]) || !(|shd[AW-1:B_WIDTH-1]);
  assign res  = fits ? shd[B_WIDTH-1:0] : (shd[AW-1] ? W_MIN : W_MAX);
endmodule

>>> rtl/core/htu_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle in Q4.30, with
// quadrant fold-out and rounding to the output fraction. Depends on htu_pkg.
module htu_cordic import htu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [31:0]                 turn,
  output logic                        done,
  output logic signed [FRAC_BITS+1:0] cos_val,
  output logic signed [FRAC_BITS+1:0] sin_val
);
  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [CORDIC_W-1:0] HALF =
    (SH > 0) ? (CORDIC_W'(1) << ((SH > 0) ? SH - 1 : 0)) : '0;
  localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

  logic signed [CORDIC_W-1:0] x, y, z, dx, dy, cq, sq, cr, sr;
  logic [1:0] quad;
  logic [4:0] it;
  logic       run;

  assign dx = y >>> it;
  assign dy = x >>> it;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (it == LAST);
      if (start) begin
        run <= 1'b1;
      end else if (run && it == LAST) begin
        run <= 1'b0;
      end
    end
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= $signed({4'b0000, turn[29:0]});
      quad <= turn[31:30];
      it   <= '0;
    end else if (run) begin
      if (!z[CORDIC_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_turn(it);
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_turn(it);
      end
      it <= it + 5'd1;
    end
  end

  always_comb begin
    case (quad)
      2'd1:    begin cq = -y; sq = x;  end
      2'd2:    begin cq = -x; sq = -y; end
      2'd3:    begin cq = y;  sq = -x; end
      default: begin cq = x;  sq = y;  end
    endcase
  end

  assign cr = (cq + HALF) >>> SH;
  assign sr = (sq + HALF) >>> SH;
  assign cos_val = cr[FRAC_BITS+1:0];
  assign sin_val = sr[FRAC_BITS+1:0];
endmodule

>>> rtl/core/homogeneous_transform_unit_core.sv
// Top level of the homogeneous transform unit: matrix store, angle
// reduction, command sequencer. Depends on htu_pkg, htu_if, htu_mac, htu_cordic.
//
//   channel | modport | carries
//   req     | sink    | cmd, angle_deg, in_x, in_y, in_z, in_w
//   rsp     | source  | out_x, out_y, out_z, out_w (transform only)
//
// Identity, save, restore, clear: done on acceptance. Translate: a matrix pass.
// Rotate: one reciprocal-multiply step per 16-bit slice of 1/360 (4 by default),
// then 24 CORDIC steps, then a matrix pass.
// Transform: four dot products, then the result register is loaded.
// Matrix passes and dot products share the single multiply-accumulate unit.
// Reset is synchronous and loads identity; a stalled result holds the last load.
module homogeneous_transform_unit_core import htu_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic     clk,
  input logic     rst,
  htu_req_if.sink   req,
  htu_rsp_if.source rsp
);
  localparam int DW  = DATA_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int EW  = (DW > FB + 2) ? DW : FB + 2;
  // |Binary angle| = floor(|deg| * 2^(32-FB) / 360), taken by reciprocal multiply.
  localparam int NX  = DW + 32 - FB;
  localparam int RS  = NX + 9;
  localparam int MW  = RS - 8;
  localparam int RCH = 16;
  localparam int NC  = (MW + RCH - 1) / RCH;
  localparam int RPW = (MW > 41) ? DW + MW : DW + 41;
  localparam int DCW = $clog2(NC + 1);
  localparam logic [RS:0] RECIP_FULL =
    (((RS+1)'(1) << RS) + (RS+1)'(DEG_PER_TURN) - (RS+1)'(1)) / (RS+1)'(DEG_PER_TURN);
  localparam logic [NC*RCH-1:0] RECIP = (NC*RCH)'(RECIP_FULL);
  localparam logic [DW-1:0] ONE_W =
    (FB < DW - 1) ? (DW'(1) << FB) : {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [EW-1:0] ONE_E = EW'(1) << FB;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_CORD, ST_ISSUE, ST_WAIT, ST_PUSH
  } state_t;

  state_t           state;
  htu_cmd_t         cmd_r;
  logic [DW-1:0]    mtx [16];
  logic [DW-1:0]    saved [3];
  logic [DW-1:0]    vec [4];
  logic [DW-1:0]    colbuf [4];
  logic [6:0]       cnt;
  logic [3:0]       rcnt;
  logic             xform;
  logic [DW-1:0]    amag;
  logic [RPW-1:0]   rp;
  logic             neg;
  logic [DCW-1:0]   dcnt;
  logic             cord_go;
  logic             out_vld;
  logic [DW-1:0]    ox, oy, oz, ow;

  logic [DCW-1:0]   rsel;
  logic [RCH-1:0]   rchunk;
  logic [DW+RCH-1:0] rprod;
  logic [31:0]      quo;
  logic [15:0]      x_lo;
  logic             rnz;
  logic [31:0]      turn;
  logic [DW:0]      mag;
  logic             cord_done;
  logic signed [FB+1:0] c_val, s_val;
  logic [1:0]       ii, jj, kk, cj;
  logic [3:0]       rd_idx;
  logic [DW-1:0]    mrd;
  logic signed [EW-1:0] e_val, cse, sse, mac_a;
  logic signed [DW-1:0] mac_b, mac_res;
  mac_ctl_t         ctl;
  logic             mac_done, last_issue;

  // Multiply the magnitude by 1/360, most significant 16-bit slice first.
  assign rsel   = DCW'(NC - 1) - dcnt;
  assign rchunk = RECIP[int'(rsel) * RCH +: RCH];
  assign rprod  = (DW+RCH)'(amag) * (DW+RCH)'(rchunk);
  assign quo    = rp[DW+40:DW+9];
  // The remainder is below 360, so its low 16 bits tell whether it is zero.
  assign x_lo   = 16'({amag, {(32-FB){1'b0}}});
  assign rnz    = x_lo != quo[15:0] * 16'(DEG_PER_TURN);
  assign turn   = neg ? (rnz ? ~quo : (32'd0 - quo)) : quo;
  assign mag    = req.angle_deg[DW-1] ? ((DW+1)'(0) - {req.angle_deg[DW-1], req.angle_deg})
                                      : {1'b0, req.angle_deg};

  htu_cordic #(.FRAC_BITS(FB)) u_cordic (
    .clk(clk), .rst(rst), .start(cord_go), .turn(turn),
    .done(cord_done), .cos_val(c_val), .sin_val(s_val)
  );

  assign jj = cnt[6:5];
  assign ii = cnt[4:3];
  assign kk = cnt[2:1];
  assign rd_idx = xform ? {ii, kk} : {kk, jj};
  assign mrd = mtx[rd_idx];
  assign cse = EW'(c_val);
  assign sse = EW'(s_val);

  // Elementary matrix entry E[ii][kk] for the latched command.
  always_comb begin
    e_val = (ii == kk) ? ONE_E : '0;
    case (cmd_r)
      CMD_ROTX: begin
        if ((ii == 2'd1 && kk == 2'd1) || (ii == 2'd2 && kk == 2'd2)) e_val = cse;
        if (ii == 2'd1 && kk == 2'd2) e_val = -sse;
        if (ii == 2'd2 && kk == 2'd1) e_val = sse;
      end
      CMD_ROTY: begin
        if ((ii == 2'd0 && kk == 2'd0) || (ii == 2'd2 && kk == 2'd2)) e_val = cse;
        if (ii == 2'd0 && kk == 2'd2) e_val = sse;
        if (ii == 2'd2 && kk == 2'd0) e_val = -sse;
      end
      CMD_ROTZ: begin
        if ((ii == 2'd0 && kk == 2'd0) || (ii == 2'd1 && kk == 2'd1)) e_val = cse;
        if (ii == 2'd0 && kk == 2'd1) e_val = -sse;
        if (ii == 2'd1 && kk == 2'd0) e_val = sse;
      end
      CMD_TRANSLATE: begin
        if (kk == 2'd3 && ii != 2'd3) e_val = EW'($signed(vec[ii]));
      end
      default: ;
    endcase
  end

  assign mac_a = xform ? EW'($signed(mrd)) : e_val;
  assign mac_b = xform ? $signed(vec[kk]) : $signed(mrd);
  assign last_issue = xform ? (cnt[4:0] == 5'd31) : (cnt == 7'd127);

  always_comb begin
    ctl.en    = (state == ST_ISSUE);
    ctl.first = (kk == 2'd0) && !cnt[0];
    ctl.hi    = cnt[0];
    ctl.last  = (kk == 2'd3) && cnt[0];
  end

  htu_mac #(.A_WIDTH(EW), .B_WIDTH(DW), .FRAC_BITS(FB)) u_mac (
    .clk(clk), .rst(rst), .ctl(ctl), .a(mac_a), .b(mac_b),
    .res(mac_res), .done(mac_done)
  );

  assign cj = rcnt[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cord_go <= 1'b0;
      out_vld <= 1'b0;
      for (int n = 0; n < 16; n++) mtx[n] <= (n % 5 == 0) ? ONE_W : '0;
      for (int n = 0; n < 3; n++) saved[n] <= '0;
    end else begin
      if (out_vld && rsp.ready && state != ST_PUSH) out_vld <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cmd_r  <= htu_cmd_t'(req.cmd);
            vec[0] <= req.in_x;
            vec[1] <= req.in_y;
            vec[2] <= req.in_z;
            vec[3] <= req.in_w;
            cnt    <= '0;
            rcnt   <= '0;
            xform  <= 1'b0;
            case (req.cmd) inside
              CMD_IDENTITY: begin
                for (int n = 0; n < 16; n++) mtx[n] <= (n % 5 == 0) ? ONE_W : '0;
              end
              CMD_ROTX, CMD_ROTY, CMD_ROTZ: begin
                amag  <= mag[DW-1:0];
                neg   <= req.angle_deg[DW-1];
                rp    <= '0;
                dcnt  <= '0;
                state <= ST_DIV;
              end
              CMD_TRANSLATE: state <= ST_ISSUE;
              CMD_TRANSFORM: begin
                xform <= 1'b1;
                state <= ST_ISSUE;
              end
              CMD_SAVE: begin
                for (int n = 0; n < 3; n++) saved[n] <= mtx[n * 4 + 3];
              end
              CMD_RESTORE: begin
                for (int n = 0; n < 3; n++) mtx[n * 4 + 3] <= saved[n];
              end
              CMD_CLEAR: begin
                for (int n = 0; n < 3; n++) mtx[n * 4 + 3] <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          rp      <= (rp << RCH) + RPW'(rprod);
          dcnt    <= dcnt + DCW'(1);
          cord_go <= (dcnt == DCW'(NC - 1));
          if (dcnt == DCW'(NC - 1)) state <= ST_CORD;
        end
        ST_CORD: begin
          cord_go <= 1'b0;
          if (cord_done) state <= ST_ISSUE;
        end
        ST_ISSUE: begin
          cnt <= cnt + 7'd1;
          if (last_issue) state <= ST_WAIT;
        end
        ST_WAIT: ;
        ST_PUSH: begin
          // Hold until the result register is free.
          if (!out_vld || rsp.ready) begin
            ox      <= colbuf[0];
            oy      <= colbuf[1];
            oz      <= colbuf[2];
            ow      <= colbuf[3];
            out_vld <= 1'b1;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (mac_done) begin
        colbuf[rcnt[1:0]] <= mac_res;
        rcnt <= rcnt + 4'd1;
        if (xform) begin
          if (rcnt == 4'd3) state <= ST_PUSH;
        end else if (rcnt[1:0] == 2'd3) begin
          // Write back one finished column.
          mtx[{2'd0, cj}] <= colbuf[0];
          mtx[{2'd1, cj}] <= colbuf[1];
          mtx[{2'd2, cj}] <= colbuf[2];
          mtx[{2'd3, cj}] <= mac_res;
          if (rcnt == 4'd15) state <= ST_IDLE;
        end
      end
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_vld;
  assign rsp.out_x = ox;
  assign rsp.out_y = oy;
  assign rsp.out_z = oz;
  assign rsp.out_w = ow;

  a_mac_phase: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == ST_ISSUE || state == ST_WAIT))
    else $error("dot product finished outside a matrix pass");
  a_push_xform: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH) |-> xform)
    else $error("result push without a transform");
  a_cordic_phase: assert property (@(posedge clk) disable iff (rst)
    cord_done |-> (state == ST_CORD))
    else $error("sine and cosine finished outside the CORDIC phase");
  a_xform_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT && xform) |-> (rcnt <= 4'd3))
    else $error("transform captured more than four outputs");
endmodule
